/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* hw/rtl/cprq_pkg.sv */
// ----------------------------------------------------------------------------
// cprq_pkg
// Types and constants of the core run queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cprq_pkg;

    // Queue depth must be a power of two: physical slots wrap by truncation.
    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int ID_BITS       = 16;
    localparam int LIFE_BITS     = 16;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int TASK_W = ID_BITS + PRIORITY_BITS + LIFE_BITS;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = ((TASK_W + 7) / 8) * 8;
    localparam int S_USER_W = MODE_W;
    // id, priority, lifetime, busy, waiting count, total count, running lifetime
    localparam int M_DATA_RAW_W = TASK_W + 1 + 2 * CNT_W + LIFE_BITS;
    localparam int M_DATA_W     = ((M_DATA_RAW_W + 7) / 8) * 8;
    localparam int M_USER_W     = 1 + STATUS_W;

    typedef struct packed {
        logic [LIFE_BITS-1:0]     life;
        logic [PRIORITY_BITS-1:0] prio;
        logic [ID_BITS-1:0]       id;
    } t_task;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_SET    = 3'd1,
        MODE_TICK   = 3'd2,
        MODE_TERM   = 3'd3,
        MODE_POP    = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_IDLE  = 2'd3
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/cprq_ram.sv */
// ----------------------------------------------------------------------------
// cprq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read during write to the same address returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/core_priority_run_queue_core.sv */
// ----------------------------------------------------------------------------
// core_priority_run_queue_core
// Running slot plus a priority-sorted waiting queue held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the operation (insert, set, tick, terminate,
//   pop), tdata the task record. Master stream: one result transfer per
//   operation, tuser holds the returned-record flag and status, tdata the
//   returned record and the occupancy of the core.
//   Set, tick, error cases and inserts into an empty queue are answered
//   from the idle state; pop and terminate with a waiting task add one
//   RAM read of the head; an insert walks the queue from the tail, one
//   entry per cycle through the RAM read port, and finishes with a write
//   to the head slot if the walk reaches it.
//   One operation is in flight at a time. The result is registered; the
//   next operation is taken while that result is being transferred.
//   When the receiver stalls, the result is held and no new operation is
//   taken. Reset empties the queue and idles the core; the RAM contents
//   are not cleared, only entries below the waiting count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module core_priority_run_queue_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] task_id, [23:16] priority_req, [39:24] lifetime
    input  wire logic [cprq_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // [2:0] mode
    input  wire logic [cprq_pkg::S_USER_W-1:0] i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [15:0] out_task_id, [23:16] out_priority, [39:24] out_lifetime,
    // [40] busy_res, [45:41] waiting_count, [50:46] total_count,
    // [66:51] running_lifetime, [71:67] zero
    output logic      [cprq_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // [0] out_valid, [2:1] status
    output logic      [cprq_pkg::M_USER_W-1:0] o_m_axis_tuser
);

    import cprq_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_HEAD,
        S_POP,
        S_PROMOTE
    } t_state;

    t_state              r_state,   n_state;
    logic [IDX_W-1:0]    r_head,    n_head;
    logic [CNT_W-1:0]    r_cnt,     n_cnt;
    logic                r_run_vld, n_run_vld;
    t_task               r_run,     n_run;
    t_task               r_req,     n_req;
    t_task               r_ret,     n_ret;
    logic [IDX_W-1:0]    r_cur,     n_cur;
    logic                r_out_vld;
    logic [M_DATA_W-1:0] r_out_data;
    logic [M_USER_W-1:0] r_out_user;

    logic                w_accept;
    t_mode               w_mode;
    t_task               w_in_task;
    logic [CNT_W-1:0]    w_cnt_dec;
    t_task               w_rdata;
    logic [TASK_W-1:0]   w_rdata_raw;

    logic                w_ram_we;
    logic [IDX_W-1:0]    w_ram_waddr;
    t_task               w_ram_wdata;
    logic [IDX_W-1:0]    w_ram_raddr;

    logic                w_res_load;
    logic                w_res_ret_vld;
    t_task               w_res_ret;
    t_status             w_res_status;
    logic [LIFE_BITS-1:0] w_res_run_life;
    logic [CNT_W-1:0]    w_res_total;
    logic [M_DATA_W-1:0] w_res_data;
    logic [M_USER_W-1:0] w_res_user;

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_vld || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_mode          = t_mode'(i_s_axis_tuser[MODE_W-1:0]);
    assign w_in_task.id    = i_s_axis_tdata[ID_BITS-1:0];
    assign w_in_task.prio  = i_s_axis_tdata[ID_BITS +: PRIORITY_BITS];
    assign w_in_task.life  = i_s_axis_tdata[ID_BITS+PRIORITY_BITS +: LIFE_BITS];
    assign w_cnt_dec       = r_cnt - CNT_W'(1);
    assign w_rdata         = t_task'(w_rdata_raw);

    cprq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata_raw)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_run_vld   = r_run_vld;
        n_run       = r_run;
        n_req       = r_req;
        n_ret       = r_ret;
        n_cur       = r_cur;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_head;
        w_ram_wdata = r_req;
        w_ram_raddr = r_head;
        w_res_load    = 1'b0;
        w_res_ret_vld = 1'b0;
        w_res_ret     = '0;
        w_res_status  = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_mode)
                        MODE_INSERT: begin
                            if (r_cnt >= CNT_W'(QUEUE_DEPTH)) begin
                                w_res_status = ST_FULL;
                                w_res_load   = 1'b1;
                            end else if (r_cnt == '0) begin
                                w_ram_we    = 1'b1;
                                w_ram_waddr = r_head;
                                w_ram_wdata = w_in_task;
                                n_cnt       = r_cnt + CNT_W'(1);
                                w_res_load  = 1'b1;
                            end else begin
                                // walk down from the tail
                                n_req       = w_in_task;
                                n_cur       = w_cnt_dec[IDX_W-1:0];
                                w_ram_raddr = r_head + w_cnt_dec[IDX_W-1:0];
                                n_state     = S_INS;
                            end
                        end
                        MODE_SET: begin
                            n_run      = w_in_task;
                            n_run_vld  = 1'b1;
                            w_res_load = 1'b1;
                        end
                        MODE_TICK: begin
                            if (r_run_vld && (r_run.life != '0)) begin
                                n_run.life = r_run.life - LIFE_BITS'(1);
                            end
                            w_res_load = 1'b1;
                        end
                        MODE_TERM: begin
                            if (!r_run_vld) begin
                                w_res_status = ST_IDLE;
                                w_res_load   = 1'b1;
                            end else if (r_cnt == '0) begin
                                n_run_vld     = 1'b0;
                                w_res_ret_vld = 1'b1;
                                w_res_ret     = r_run;
                                w_res_load    = 1'b1;
                            end else begin
                                n_ret       = r_run;
                                w_ram_raddr = r_head;
                                n_state     = S_PROMOTE;
                            end
                        end
                        MODE_POP: begin
                            if (r_cnt == '0) begin
                                w_res_status = ST_EMPTY;
                                w_res_load   = 1'b1;
                            end else begin
                                w_ram_raddr = r_head;
                                n_state     = S_POP;
                            end
                        end
                        default: begin
                            w_res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                // w_rdata holds logical entry r_cur
                w_ram_we    = 1'b1;
                w_ram_waddr = r_head + r_cur + IDX_W'(1);
                if (w_rdata.prio >= r_req.prio) begin
                    w_ram_wdata = w_rdata;
                    if (r_cur == '0) begin
                        n_state = S_INS_HEAD;
                    end else begin
                        n_cur       = r_cur - IDX_W'(1);
                        w_ram_raddr = r_head + r_cur - IDX_W'(1);
                    end
                end else begin
                    w_ram_wdata = r_req;
                    n_cnt       = r_cnt + CNT_W'(1);
                    w_res_load  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_INS_HEAD: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_head;
                w_ram_wdata = r_req;
                n_cnt       = r_cnt + CNT_W'(1);
                w_res_load  = 1'b1;
                n_state     = S_IDLE;
            end
            S_POP: begin
                n_head        = r_head + IDX_W'(1);
                n_cnt         = w_cnt_dec;
                w_res_ret_vld = 1'b1;
                w_res_ret     = w_rdata;
                w_res_load    = 1'b1;
                n_state       = S_IDLE;
            end
            S_PROMOTE: begin
                n_run         = w_rdata;
                n_head        = r_head + IDX_W'(1);
                n_cnt         = w_cnt_dec;
                w_res_ret_vld = 1'b1;
                w_res_ret     = r_ret;
                w_res_load    = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_res_run_life = n_run_vld ? n_run.life : '0;
        w_res_total    = n_cnt + CNT_W'(n_run_vld);
        w_res_data     = M_DATA_W'({w_res_run_life, w_res_total, n_cnt, n_run_vld,
                                    w_res_ret.life, w_res_ret.prio, w_res_ret.id});
        w_res_user     = {w_res_status, w_res_ret_vld};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_cnt     <= '0;
            r_run_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_cnt     <= n_cnt;
            r_run_vld <= n_run_vld;
            if (w_res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        r_run <= n_run;
        r_req <= n_req;
        r_ret <= n_ret;
        r_cur <= n_cur;
        if (w_res_load) begin
            r_out_data <= w_res_data;
            r_out_user <= w_res_user;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    `ASSERT_CLK_RST(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_CLK_RST(a_walk_no_overlap, i_clk, i_rst_n,
        (r_state == S_INS) |-> (w_ram_waddr != w_ram_raddr))
    `ASSERT_CLK_RST(a_total_consistent, i_clk, i_rst_n,
        o_m_axis_tvalid |-> (o_m_axis_tdata[TASK_W+1+CNT_W +: CNT_W] ==
            o_m_axis_tdata[TASK_W+1 +: CNT_W] + CNT_W'(o_m_axis_tdata[TASK_W])))
    `ASSERT_CLK(a_reset_quiet, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

`default_nettype wire
